[rtl/hcbp_pkg.sv]
`default_nettype none

package hcbp_pkg;

  localparam int BYTE_BITS        = 8;
  localparam int MAX_CODE_LEN     = 32;
  localparam int CODE_BITS        = 32;
  localparam int LEN_BITS         = 6;
  localparam int SYM_BITS         = 8;
  localparam int ZCNT_BITS        = 4;
  localparam int DEF_SYMBOL_COUNT = 128;
  localparam int QUEUE_DEPTH      = 2;
  localparam int ZSTORE_DEPTH     = 256;
  localparam int ACC_BITS         = BYTE_BITS - 1;
  localparam int WORK_BITS        = CODE_BITS + BYTE_BITS;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } hcbp_action_e;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_ERROR  = 2'd2
  } hcbp_kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } hcbp_state_e;

  typedef struct packed {
    hcbp_kind_e             kind;
    logic [CODE_BITS-1:0]   code;
    logic [LEN_BITS-1:0]    len;
  } hcbp_cmd_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0]   out_byte;
    logic [3:0]             bits_in_byte;
    logic [ZCNT_BITS-1:0]   zero_count;
    logic [ZCNT_BITS-1:0]   collision;
    logic                   error;
    logic                   last;
  } hcbp_res_t;

  function automatic logic [ZCNT_BITS-1:0] lead_zeros(logic [BYTE_BITS-1:0] left,
                                                      logic [3:0] k);
    logic [ZCNT_BITS-1:0] z;
    logic                 found;
    z     = '0;
    found = 1'b0;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (!found && !left[i]) begin
        z = z + 1'b1;
      end else begin
        found = 1'b1;
      end
    end
    if (z > k) begin
      z = k;
    end
    return z;
  endfunction

endpackage

`default_nettype wire

[rtl/hcbp_front.sv]
`default_nettype none

module hcbp_front import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            in_action_i,
  input  wire logic [SYM_BITS-1:0]   in_symbol_i,
  input  wire logic [CODE_BITS-1:0]  in_code_i,
  input  wire logic [LEN_BITS-1:0]   in_len_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output hcbp_cmd_t                  cmd_o
);

  localparam int AddrW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LenCapInt = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
  localparam logic [LEN_BITS-1:0] LenCap = LEN_BITS'(LenCapInt);
  localparam logic [SYM_BITS:0]   SymLimit = (SYM_BITS + 1)'(SYMBOL_COUNT);

  logic [CODE_BITS-1:0] word_mem [SYMBOL_COUNT];
  logic [LEN_BITS-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_vld_q;

  logic                 s1_valid_q, s1_valid_d;
  hcbp_kind_e           s1_kind_q, s1_kind_d;
  logic [CODE_BITS-1:0] word_rd_q;
  logic [LEN_BITS-1:0]  len_rd_q;
  logic                 vld_rd_q;

  logic                 in_fire;
  logic                 sym_ok;
  logic [AddrW-1:0]     idx;
  logic                 do_load;
  logic                 do_read;
  logic                 need_push;
  logic [LEN_BITS-1:0]  len_sat;
  logic [LEN_BITS-1:0]  s1_len;
  hcbp_action_e         act;

  assign act        = hcbp_action_e'(in_action_i);
  assign in_ready_o = !s1_valid_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign sym_ok     = {1'b0, in_symbol_i} < SymLimit;
  assign idx        = in_symbol_i[AddrW-1:0];
  assign len_sat    = (in_len_i > LenCap) ? LenCap : in_len_i;

  always_comb begin
    do_load   = 1'b0;
    do_read   = 1'b0;
    need_push = 1'b0;
    s1_kind_d = s1_kind_q;
    case (act)
      ACT_LOAD: begin
        if (sym_ok) begin
          do_load = 1'b1;
        end else begin
          need_push = 1'b1;
          s1_kind_d = CMD_ERROR;
        end
      end
      ACT_ENCODE: begin
        need_push = 1'b1;
        if (sym_ok) begin
          do_read   = 1'b1;
          s1_kind_d = CMD_ENCODE;
        end else begin
          s1_kind_d = CMD_ERROR;
        end
      end
      ACT_FLUSH: begin
        need_push = 1'b1;
        s1_kind_d = CMD_FLUSH;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = need_push;
    end else if (s1_valid_q && cmd_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= CMD_FLUSH;
      len_vld_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        s1_kind_q <= s1_kind_d;
      end
      if (in_fire && do_load) begin
        len_vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && do_load) begin
      word_mem[idx] <= in_code_i;
      len_mem[idx]  <= len_sat;
    end
    if (in_fire && do_read) begin
      word_rd_q <= word_mem[idx];
      len_rd_q  <= len_mem[idx];
      vld_rd_q  <= len_vld_q[idx];
    end
  end

  // left-align the code word: bits above its length fall off the top
  assign s1_len      = vld_rd_q ? len_rd_q : '0;
  assign cmd_valid_o = s1_valid_q;
  assign cmd_o.kind  = s1_kind_q;
  assign cmd_o.len   = (s1_kind_q == CMD_ENCODE) ? s1_len : '0;
  assign cmd_o.code  = (s1_kind_q == CMD_ENCODE) ?
                       (word_rd_q << (LEN_BITS'(CODE_BITS) - s1_len)) : '0;

endmodule

`default_nettype wire

[rtl/hcbp_fifo.sv]
`default_nettype none

module hcbp_fifo import hcbp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire hcbp_cmd_t in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output hcbp_cmd_t      out_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(QUEUE_DEPTH);

  hcbp_cmd_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign in_ready_o  = count_q != Full;
  assign out_valid_o = count_q != '0;
  assign out_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i;
    end
  end

endmodule

`default_nettype wire

[rtl/hcbp_back.sv]
`default_nettype none

module hcbp_back import hcbp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  output logic           cmd_ready_o,
  input  wire hcbp_cmd_t cmd_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output hcbp_res_t      res_o
);

  localparam int ZAddrW = $clog2(ZSTORE_DEPTH);

  hcbp_state_e            state_q, state_d;
  logic [ACC_BITS-1:0]    acc_q, acc_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [WORK_BITS-1:0]   work_q, work_d;
  logic [LEN_BITS-1:0]    total_q, total_d;

  logic                   rec_valid;
  hcbp_res_t              rec;
  logic [WORK_BITS-1:0]   enc_work;
  logic [LEN_BITS-1:0]    enc_total;
  logic [LEN_BITS-1:0]    rem;
  logic [BYTE_BITS-1:0]   flush_left;

  logic                   b_valid_q;
  hcbp_res_t              b_rec_q;
  hcbp_res_t              b_out;
  logic [ZCNT_BITS-1:0]   b_mem_q;
  logic                   b_vld_q;
  logic                   b_hit_q;
  logic [ZCNT_BITS-1:0]   b_fwd_q;
  logic                   b_fire, a_free;
  logic [ZCNT_BITS-1:0]   b_store;
  logic                   b_wr, b_coll;
  logic [ZCNT_BITS-1:0]   coll_q, coll_new;

  logic [ZCNT_BITS-1:0]   zmem [ZSTORE_DEPTH];
  logic [ZSTORE_DEPTH-1:0] zvld_q;

  logic                   c_valid_q;
  hcbp_res_t              c_rec_q;

  assign b_fire = b_valid_q && (!c_valid_q || res_ready_i);
  assign a_free = !b_valid_q || b_fire;

  assign enc_work   = {acc_q, {(CODE_BITS + 1){1'b0}}} |
                      ({cmd_i.code, {BYTE_BITS{1'b0}}} >> cnt_q);
  assign enc_total  = LEN_BITS'(cnt_q) + cmd_i.len;
  assign rem        = total_q - LEN_BITS'(BYTE_BITS);
  assign flush_left = {acc_q, 1'b0};

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    work_d      = work_q;
    total_d     = total_q;
    cmd_ready_o = 1'b0;
    rec_valid   = 1'b0;
    rec         = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && a_free) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.kind)
            CMD_ERROR: begin
              rec_valid  = 1'b1;
              rec.error  = 1'b1;
              rec.last   = 1'b1;
            end
            CMD_FLUSH: begin
              if (cnt_q != '0) begin
                rec_valid        = 1'b1;
                rec.out_byte     = flush_left >> (4'(BYTE_BITS) - 4'(cnt_q));
                rec.bits_in_byte = 4'(cnt_q);
                rec.zero_count   = lead_zeros(flush_left, 4'(cnt_q));
                rec.last         = 1'b1;
                acc_d            = '0;
                cnt_d            = '0;
              end
            end
            CMD_ENCODE: begin
              if (enc_total >= LEN_BITS'(BYTE_BITS)) begin
                work_d  = enc_work;
                total_d = enc_total;
                state_d = BK_EMIT;
              end else begin
                acc_d = enc_work[WORK_BITS-1 -: ACC_BITS];
                cnt_d = enc_total[2:0];
              end
            end
            default: begin
              rec_valid = 1'b0;
            end
          endcase
        end
      end
      BK_EMIT: begin
        if (a_free) begin
          rec_valid        = 1'b1;
          rec.out_byte     = work_q[WORK_BITS-1 -: BYTE_BITS];
          rec.bits_in_byte = 4'(BYTE_BITS);
          rec.zero_count   = lead_zeros(work_q[WORK_BITS-1 -: BYTE_BITS], 4'(BYTE_BITS));
          rec.last         = rem < LEN_BITS'(BYTE_BITS);
          work_d           = work_q << BYTE_BITS;
          total_d          = rem;
          if (rem < LEN_BITS'(BYTE_BITS)) begin
            acc_d   = work_q[WORK_BITS-BYTE_BITS-1 -: ACC_BITS];
            cnt_d   = rem[2:0];
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign b_store  = b_hit_q ? b_fwd_q : (b_vld_q ? b_mem_q : '0);
  assign b_wr     = b_valid_q && !b_rec_q.error && (b_rec_q.zero_count != '0) &&
                    (b_store == '0);
  assign b_coll   = b_valid_q && !b_rec_q.error && !b_wr &&
                    (b_store != b_rec_q.zero_count);
  assign coll_new = b_coll ? b_rec_q.zero_count : coll_q;

  always_comb begin
    b_out           = b_rec_q;
    b_out.collision = coll_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      total_q   <= '0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      coll_q    <= '0;
      zvld_q    <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      if (rec_valid) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        c_valid_q <= 1'b1;
        coll_q    <= coll_new;
      end else if (res_ready_i) begin
        c_valid_q <= 1'b0;
      end
      if (b_fire && b_wr) begin
        zvld_q[b_rec_q.out_byte[ZAddrW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (rec_valid) begin
      b_rec_q <= rec;
      b_mem_q <= zmem[rec.out_byte[ZAddrW-1:0]];
      b_vld_q <= zvld_q[rec.out_byte[ZAddrW-1:0]];
      b_hit_q <= b_fire && b_wr && (b_rec_q.out_byte == rec.out_byte);
      b_fwd_q <= b_rec_q.zero_count;
    end
    if (b_fire && b_wr) begin
      zmem[b_rec_q.out_byte[ZAddrW-1:0]] <= b_rec_q.zero_count;
    end
    if (b_fire) begin
      c_rec_q <= b_out;
    end
  end

  assign res_valid_o = c_valid_q;
  assign res_o       = c_rec_q;

endmodule

`default_nettype wire

[rtl/huffman_code_bit_packer.sv]
// Huffman code bit packer.
// Input stream: tuser carries the action (load table entry, encode symbol, flush);
// tdata carries symbol, code word and code length. Load entries first, then encode.
// Output stream: one word per packed byte, full bytes MSB-first as collected, a
// flushed partial byte right-aligned; tuser flags a dropped out-of-range symbol,
// tlast marks the final word caused by one input word.
// Output path: front stage, queue, back sequencer (emit state for encodes only),
// zero-count lookup stage, output register.
// The back sequencer emits one byte per cycle while the output is not stalled; an
// encode that completes bytes holds it in its emit state until all are out, and it
// takes no new command meanwhile. Load words with an in-range symbol are written
// in the front and never reach the back. The front accepts new words while the
// back is busy, until the queue and the front's own stage are full.
// Reset clears the code-length table and the zero-count table through valid bits,
// so no clearing pass follows reset; the code word table itself is not cleared.
// When the receiver stalls, the output word holds and the back stops; the front
// keeps taking words until the queue and its own stage are full.
`default_nettype none

module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte, [11:8] bits_in_byte, [15:12] zero_count, [19:16] collision,
  // [23:20] zero
  output logic [23:0]      m_axis_tdata,
  // [0] error
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic      cmd_valid, cmd_ready;
  hcbp_cmd_t cmd;
  logic      q_valid, q_ready;
  hcbp_cmd_t q_cmd;
  hcbp_res_t res;

  hcbp_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_symbol_i (s_axis_tdata[7:0]),
    .in_code_i   (s_axis_tdata[39:8]),
    .in_len_i    (s_axis_tdata[45:40]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  hcbp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (cmd_ready),
    .in_i        (cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_o       (q_cmd)
  );

  hcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0000, res.collision, res.zero_count, res.bits_in_byte,
                         res.out_byte};
  assign m_axis_tuser = res.error;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
